>>> rtl/pta_pkg.sv
// shared types and codes for the peer table with aging
package pta_pkg;

  // action codes
  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_FIND     = 3'd2,
    ACT_DISCOVER = 3'd3,
    ACT_EXPIRE   = 3'd4,
    ACT_DUMP     = 3'd5
  } act_t;

  // result codes
  localparam logic [1:0] CODE_OK        = 2'd0;
  localparam logic [1:0] CODE_NOT_FOUND = 2'd1;
  localparam logic [1:0] CODE_FULL      = 2'd2;

  localparam logic [31:0] AGE_LIMIT_RESET = 32'd300;
  localparam logic [7:0]  STATUS_SEEN     = 8'd1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  // one table entry
  typedef struct packed {
    logic [255:0] key;
    logic [31:0]  address;
    logic [15:0]  port;
    logic [31:0]  seen;
    logic [7:0]   status;
  } entry_t;

  // per-cell control
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

>>> rtl/peer_table_with_aging_core.sv
// peer table with aging: control, cell chain and result register
// add, unused actions: straight to ST_FIN; others scan each held entry first
// one action at a time: no new input is taken until the action is done
// chain rotates one entry per cycle via cell 0, compared there, if slot_free
// dump gives one result per entry, each waiting for the previous transfer
// reset (rst, synchronous): table empty, age limit 300, entry contents unset
module peer_table_with_aging_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [2:0]   action,
  input  logic [63:0]  key_word_0,
  input  logic [63:0]  key_word_1,
  input  logic [63:0]  key_word_2,
  input  logic [63:0]  key_word_3,
  input  logic [31:0]  peer_address,
  input  logic [15:0]  peer_port,
  input  logic [31:0]  seen_stamp,
  input  logic [7:0]   peer_status,
  input  logic [31:0]  now_stamp,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   code,
  output logic [63:0]  out_key_0,
  output logic [63:0]  out_key_1,
  output logic [63:0]  out_key_2,
  output logic [63:0]  out_key_3,
  output logic [31:0]  out_address,
  output logic [15:0]  out_port,
  output logic [31:0]  out_seen,
  output logic [7:0]   out_status,
  output logic [4:0]   entries_held,
  output logic [4:0]   entries_removed,
  output logic         last
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  pta_pkg::state_t state, state_next;
  pta_pkg::act_t   act;
  pta_pkg::entry_t in_e, res_e, res_e_next, head, load_data, head_mod;
  pta_pkg::entry_t oe;
  pta_pkg::entry_t q [TABLE_DEPTH];
  logic [31:0]   now, limit;
  logic [CW-1:0] n, n_next, rem, rem_next, removed, removed_next;
  logic [CW-1:0] load_idx;
  logic          load_en, shift_en;
  logic          found, found_next;
  logic          in_xfer, slot_free, match, drop, first_hit;
  logic          ov;
  logic          o_load;
  logic [1:0]    oc, oc_next;
  logic          olast_next;
  logic [CW-1:0] orem_next;
  pta_pkg::entry_t oe_next;
  logic [4:0]    oheld, orem;
  logic          olast;

  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign slot_free = !ov || out_ready;
  assign head      = q[0];

  // age limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= pta_pkg::AGE_LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  // cell chain
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pta_pkg::cell_ctrl_t ctrl;
    pta_pkg::entry_t nbr;
    assign ctrl.shift = shift_en;
    assign ctrl.load  = load_en && (load_idx == CW'(i));
    if (i == TABLE_DEPTH - 1) begin : g_top
      assign nbr = load_data;
    end else begin : g_mid
      assign nbr = q[i+1];
    end
    pta_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .nbr       (nbr),
      .load_data (load_data),
      .q         (q[i])
    );
  end

  // head compare and per-action decisions
  assign match     = (head.key == in_e.key);
  assign first_hit = match && !found;
  always_comb begin
    head_mod = head;
    if (act == pta_pkg::ACT_DISCOVER && first_hit) begin
      head_mod.seen   = now;
      head_mod.status = pta_pkg::STATUS_SEEN;
    end
  end
  assign drop = (act == pta_pkg::ACT_REMOVE && first_hit) ||
                (act == pta_pkg::ACT_EXPIRE && ((now - head.seen) > limit));

  // controller state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pta_pkg::ST_IDLE;
      n     <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act           <= pta_pkg::act_t'(action);
      in_e.key      <= {key_word_3, key_word_2, key_word_1, key_word_0};
      in_e.address  <= peer_address;
      in_e.port     <= peer_port;
      in_e.seen     <= seen_stamp;
      in_e.status   <= peer_status;
      now           <= now_stamp;
    end
    rem     <= rem_next;
    found   <= found_next;
    removed <= removed_next;
    res_e   <= res_e_next;
  end

  // next state, chain control and result
  always_comb begin
    state_next   = state;
    n_next       = n;
    rem_next     = rem;
    found_next   = found;
    removed_next = removed;
    res_e_next   = res_e;
    in_ready     = 1'b0;
    shift_en     = 1'b0;
    load_en      = 1'b0;
    load_idx     = n - ONE_C;
    load_data    = head_mod;
    o_load       = 1'b0;
    oc_next      = pta_pkg::CODE_OK;
    oe_next      = '0;
    orem_next    = '0;
    olast_next   = 1'b1;
    case (state)
      pta_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rem_next     = n;
          found_next   = 1'b0;
          removed_next = '0;
          if (n != '0 && (action == pta_pkg::ACT_REMOVE || action == pta_pkg::ACT_FIND ||
              action == pta_pkg::ACT_DISCOVER || action == pta_pkg::ACT_EXPIRE ||
              action == pta_pkg::ACT_DUMP)) begin
            state_next = pta_pkg::ST_SCAN;
          end else begin
            state_next = pta_pkg::ST_FIN;
          end
        end
      end
      pta_pkg::ST_SCAN: begin
        if (slot_free) begin
          shift_en = 1'b1;
          rem_next = rem - ONE_C;
          if (drop) begin
            n_next       = n - ONE_C;
            removed_next = removed + ONE_C;
          end else begin
            load_en = 1'b1;
          end
          if (first_hit) begin
            found_next = 1'b1;
            res_e_next = head_mod;
          end
          if (act == pta_pkg::ACT_DUMP) begin
            // one result per entry
            o_load     = 1'b1;
            oe_next    = head;
            olast_next = (rem == ONE_C);
          end
          if (rem == ONE_C) begin
            state_next = (act == pta_pkg::ACT_DUMP) ? pta_pkg::ST_IDLE : pta_pkg::ST_FIN;
          end
        end
      end
      pta_pkg::ST_FIN: begin
        if (slot_free) begin
          o_load     = 1'b1;
          state_next = pta_pkg::ST_IDLE;
          load_idx   = n;
          load_data  = in_e;
          orem_next  = removed;
          case (act)
            pta_pkg::ACT_ADD: begin
              if (n < DEPTH_C) begin
                load_en = 1'b1;
                n_next  = n + ONE_C;
              end else begin
                oc_next = pta_pkg::CODE_FULL;
              end
            end
            pta_pkg::ACT_REMOVE, pta_pkg::ACT_FIND: begin
              oc_next = found ? pta_pkg::CODE_OK : pta_pkg::CODE_NOT_FOUND;
              if (act == pta_pkg::ACT_FIND && found) begin
                oe_next = res_e;
              end
            end
            pta_pkg::ACT_DISCOVER: begin
              if (found) begin
                oe_next = res_e;
              end else if (n < DEPTH_C) begin
                load_en = 1'b1;
                n_next  = n + ONE_C;
                oe_next = in_e;
              end else begin
                oc_next = pta_pkg::CODE_FULL;
              end
            end
            default: begin
              oc_next = pta_pkg::CODE_OK;
            end
          endcase
        end
      end
      default: begin
        state_next = pta_pkg::ST_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (o_load) begin
      ov <= 1'b1;
    end else if (out_ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      oc    <= oc_next;
      oe    <= oe_next;
      oheld <= 5'(n_next);
      orem  <= 5'(orem_next);
      olast <= olast_next;
    end
  end

  assign out_valid       = ov;
  assign code            = oc;
  assign out_key_0       = oe.key[63:0];
  assign out_key_1       = oe.key[127:64];
  assign out_key_2       = oe.key[191:128];
  assign out_key_3       = oe.key[255:192];
  assign out_address     = oe.address;
  assign out_port        = oe.port;
  assign out_seen        = oe.seen;
  assign out_status      = oe.status;
  assign entries_held    = oheld;
  assign entries_removed = orem;
  assign last            = olast;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) n <= DEPTH_C)
    else $error("fill count above table depth");
  a_scan_rem: assert property (@(posedge clk) disable iff (rst)
    state == pta_pkg::ST_SCAN |-> rem != '0)
    else $error("scan with no steps left");
  a_busy_after: assert property (@(posedge clk) disable iff (rst) in_xfer |=> !in_ready)
    else $error("input taken while an action is in progress");
  a_result_once: assert property (@(posedge clk) disable iff (rst)
    o_load |-> slot_free)
    else $error("result written over a pending transfer");
`endif

endmodule

>>> rtl/pta_cell.sv
// one storage cell of the entry chain
module pta_cell (
  input  logic              clk,
  input  pta_pkg::cell_ctrl_t ctrl,
  input  pta_pkg::entry_t   nbr,
  input  pta_pkg::entry_t   load_data,
  output pta_pkg::entry_t   q
);

  // load has priority over the shift from the upper neighbor
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= load_data;
    end else if (ctrl.shift) begin
      q <= nbr;
    end
  end

endmodule
